/* rtl/quaternion_slerp_assert.svh */
// Assertion macros shared by the quaternion slerp RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef QUATERNION_SLERP_ASSERT_SVH
`define QUATERNION_SLERP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define QSL_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define QSL_ASSERT(lbl, prop, msg)
`define QSL_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/qsl_pkg.sv */
// ----------------------------------------------------------------------------
// qsl_pkg
// Types, widths, constants and helper functions of the quaternion slerp block.
// ----------------------------------------------------------------------------
`default_nettype none

package qsl_pkg;

	localparam int CB    = 16;          // component width
	localparam int FB    = 14;          // fraction bits of Q2.F
	localparam int ANG   = 30;          // angle and weight fraction bits
	localparam int STEPS = 30;          // CORDIC iterations
	localparam int SCALE = ANG - FB;
	localparam int QDEPTH = 4;

	localparam int VW  = 34;            // CORDIC x and y width
	localparam int ZW  = 33;            // CORDIC angle width
	localparam int HW  = 31;            // nonnegative angle width
	localparam int QW  = ANG + 1;       // quotient width
	localparam int NW  = VW - 1 + FB;   // dividend width
	localparam int PAW = CB + QW + 1;
	localparam int PBW = CB + QW + 2;
	localparam int ACW = PBW + 1;
	localparam int RSW = ACW - ANG;

	localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};
	localparam logic [ANG-1:0] INV_GAIN = ANG'(652032874);

	typedef logic signed [CB-1:0] comp_t;
	typedef logic signed [CB:0]   compx_t;
	typedef logic [FB:0]          frac_t;
	typedef logic signed [RSW-1:0] rs_t;

	typedef enum logic [1:0] {
		PATH_FIRST = 2'd0,
		PATH_AVG   = 2'd1,
		PATH_SLERP = 2'd2
	} path_t;

	typedef struct packed {
		comp_t  [3:0] a;
		compx_t [3:0] b;
		frac_t        t;
		logic [FB-1:0] c;
		frac_t        s;
		path_t        path;
	} job_t;

	localparam rs_t SAT_HI = RSW'(2 ** (CB - 1) - 1);
	localparam rs_t SAT_LO = RSW'(-(2 ** (CB - 1)));

	function automatic logic [ANG-1:0] atan_at(input int unsigned i);
		logic [ANG-1:0] v;
		case (i)
			0: v = ANG'(843314857);
			1: v = ANG'(497837829);
			2: v = ANG'(263043837);
			3: v = ANG'(133525159);
			4: v = ANG'(67021686);
			5: v = ANG'(33543516);
			6: v = ANG'(16775851);
			7: v = ANG'(8388437);
			8: v = ANG'(4194283);
			9: v = ANG'(2097149);
			default: v = ANG'(1) << (ANG - i);
		endcase
		return v;
	endfunction

	function automatic comp_t sat_comp(input rs_t v);
		comp_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[CB-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[CB-1:0];
		end else begin
			r = v[CB-1:0];
		end
		return r;
	endfunction

	function automatic logic sat_hit(input rs_t v);
		return (v > SAT_HI) || (v < SAT_LO);
	endfunction

endpackage

`default_nettype wire

/* rtl/qsl_front.sv */
// ----------------------------------------------------------------------------
// qsl_front
// Dot product, hemisphere fix-up, half-angle sine by a digit-per-stage square
// root, and classification of each item into its result path.
// ----------------------------------------------------------------------------
`default_nettype none

module qsl_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire qsl_pkg::comp_t [3:0]     a_in,
	input  wire qsl_pkg::comp_t [3:0]     b_in,
	input  wire qsl_pkg::frac_t           t_in,
	input  wire qsl_pkg::frac_t           thr,
	output logic                          push_valid,
	input  wire logic                     push_ready,
	output qsl_pkg::job_t                 push_job
);

	localparam int CB   = qsl_pkg::CB;
	localparam int FB   = qsl_pkg::FB;
	localparam int DW   = 2 * CB + 2;
	localparam int DOTW = DW - FB;
	localparam int RW   = 2 * FB + 1;
	localparam int SQ   = FB + 1;
	localparam logic [RW-1:0] RAD_FULL = RW'(1) << (2 * FB);

	logic en;

	logic                     v_s1;
	qsl_pkg::comp_t [3:0]     a_s1, b_s1;
	qsl_pkg::frac_t           t_s1;
	logic signed [2*CB-1:0]   p_s1 [4];

	logic                     v_s2;
	qsl_pkg::comp_t [3:0]     a_s2, b_s2;
	qsl_pkg::frac_t           t_s2;
	logic signed [DOTW-1:0]   dot_s2;

	logic                     v_s3;
	qsl_pkg::job_t            job_s3;
	logic [RW-1:0]            rad_s3;

	logic                     sq_v_s   [SQ];
	logic [RW-1:0]            sq_n_s   [SQ];
	logic [RW:0]              sq_r_s   [SQ];
	qsl_pkg::job_t            sq_job_s [SQ];

	logic signed [DW-1:0]     psum;
	logic                     neg;
	logic [DOTW-1:0]          absd;
	logic                     big;
	logic [FB-1:0]            cval;
	qsl_pkg::compx_t [3:0]    bfix;
	qsl_pkg::frac_t           s_fin;

	assign en       = !push_valid || push_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_in;
			b_s1 <= b_in;
			t_s1 <= (t_in > qsl_pkg::ONE) ? qsl_pkg::ONE : t_in;
			for (int i = 0; i < 4; i++) begin
				p_s1[i] <= $signed(a_in[i]) * $signed(b_in[i]);
			end
		end
	end

	// The dot product is the floor of the exact sum over 2^F, taken after the full products are added.
	assign psum = DW'(p_s1[0]) + DW'(p_s1[1]) + DW'(p_s1[2]) + DW'(p_s1[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			t_s2   <= t_s1;
			dot_s2 <= psum[DW-1:FB];
		end
	end

	always_comb begin
		neg  = dot_s2[DOTW-1];
		absd = neg ? DOTW'(-dot_s2) : DOTW'(dot_s2);
		big  = absd >= DOTW'(qsl_pkg::ONE);
		cval = absd[FB-1:0];
		for (int i = 0; i < 4; i++) begin
			bfix[i] = neg ? -qsl_pkg::compx_t'($signed(b_s2[i]))
			              : qsl_pkg::compx_t'($signed(b_s2[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s3.a    <= a_s2;
			job_s3.b    <= bfix;
			job_s3.t    <= t_s2;
			job_s3.c    <= cval;
			job_s3.s    <= '0;
			job_s3.path <= big ? qsl_pkg::PATH_FIRST : qsl_pkg::PATH_SLERP;
			rad_s3      <= RAD_FULL - RW'(cval) * RW'(cval);
		end
	end

	// One root bit per stage, highest first.
	for (genvar k = 0; k < SQ; k++) begin : g_sq
		localparam logic [RW:0] BIT = (RW + 1)'(1) << (2 * (SQ - 1 - k));
		logic                v_in;
		logic [RW-1:0]       n_in;
		logic [RW:0]         r_in;
		qsl_pkg::job_t       j_in;
		logic [RW:0]         trial;
		logic                ge;

		if (k == 0) begin : g_head
			assign v_in = v_s3;
			assign n_in = rad_s3;
			assign r_in = '0;
			assign j_in = job_s3;
		end else begin : g_body
			assign v_in = sq_v_s[k-1];
			assign n_in = sq_n_s[k-1];
			assign r_in = sq_r_s[k-1];
			assign j_in = sq_job_s[k-1];
		end

		assign trial = r_in + BIT;
		assign ge    = (RW + 1)'(n_in) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (en) begin
				sq_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_job_s[k] <= j_in;
				if (ge) begin
					sq_n_s[k] <= n_in - trial[RW-1:0];
					sq_r_s[k] <= (r_in >> 1) + BIT;
				end else begin
					sq_n_s[k] <= n_in;
					sq_r_s[k] <= r_in >> 1;
				end
			end
		end
	end

	assign s_fin      = sq_r_s[SQ-1][FB:0];
	assign push_valid = sq_v_s[SQ-1];

	always_comb begin
		push_job   = sq_job_s[SQ-1];
		push_job.s = s_fin;
		if (sq_job_s[SQ-1].path != qsl_pkg::PATH_FIRST) begin
			push_job.path = (s_fin < thr) ? qsl_pkg::PATH_AVG : qsl_pkg::PATH_SLERP;
		end
	end

endmodule

`default_nettype wire

/* rtl/qsl_queue.sv */
// ----------------------------------------------------------------------------
// qsl_queue
// Short first-in first-out queue between the classifying front and the
// interpolating back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_slerp_assert.svh"

module qsl_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire qsl_pkg::job_t push_job,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output qsl_pkg::job_t      pop_job
);

	localparam int DEPTH = qsl_pkg::QDEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	qsl_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push_fire, pop_fire;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`QSL_ASSERT(a_fill_grows, push_fire && !pop_fire |=> count_q == $past(count_q) + 1'b1, "queue fill did not grow on a lone push")
	`QSL_ASSERT(a_fill_shrinks, pop_fire && !push_fire |=> count_q == $past(count_q) - 1'b1, "queue fill did not shrink on a lone pop")
	`QSL_NEVER(a_ptr_fill, (wr_ptr_q - rd_ptr_q) != count_q[PW-1:0], "queue pointers disagree with fill count")

endmodule

`default_nettype wire

/* rtl/qsl_back.sv */
// ----------------------------------------------------------------------------
// qsl_back
// Half angle by vectoring CORDIC, split by the fraction, two rotation CORDICs
// for the sines, two restoring dividers for the weights, and the final blend
// with saturation and path selection.
// ----------------------------------------------------------------------------
`default_nettype none

module qsl_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire qsl_pkg::job_t        pop_job,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output qsl_pkg::comp_t [3:0]      res,
	output logic [1:0]                path,
	output logic                      sat
);

	localparam int CB    = qsl_pkg::CB;
	localparam int FB    = qsl_pkg::FB;
	localparam int ANG   = qsl_pkg::ANG;
	localparam int STEPS = qsl_pkg::STEPS;
	localparam int SCALE = qsl_pkg::SCALE;
	localparam int VW    = qsl_pkg::VW;
	localparam int ZW    = qsl_pkg::ZW;
	localparam int HW    = qsl_pkg::HW;
	localparam int QW    = qsl_pkg::QW;
	localparam int NW    = qsl_pkg::NW;
	localparam int PAW   = qsl_pkg::PAW;
	localparam int PBW   = qsl_pkg::PBW;
	localparam int ACW   = qsl_pkg::ACW;
	localparam int RSW   = qsl_pkg::RSW;
	localparam int DS    = QW;
	localparam logic [QW-1:0] W_ONE = QW'(1) << ANG;
	localparam logic signed [ACW-1:0] ROUND = ACW'(1) << (ANG - 1);

	logic en;

	// vectoring CORDIC
	logic                  vv_s [STEPS];
	logic signed [VW-1:0]  vx_s [STEPS];
	logic signed [VW-1:0]  vy_s [STEPS];
	logic signed [ZW-1:0]  vz_s [STEPS];
	qsl_pkg::job_t         vj_s [STEPS];

	// angle split
	logic                  v_mul_s;
	logic [HW-1:0]         h_mul_s;
	logic [FB+HW:0]        th_mul_s;
	qsl_pkg::job_t         j_mul_s;
	logic                  v_ang_s;
	logic [HW-1:0]         ang_s [2];
	qsl_pkg::job_t         j_ang_s;
	logic signed [ZW-1:0]  hz;

	// rotation CORDICs, lane 0 for the first weight, lane 1 for the second
	logic                  rv_s [STEPS];
	qsl_pkg::job_t         rj_s [STEPS];
	logic signed [VW-1:0]  rx_s [2][STEPS];
	logic signed [VW-1:0]  ry_s [2][STEPS];
	logic signed [ZW-1:0]  rz_s [2][STEPS];

	// dividers
	logic                  dv_s   [DS];
	qsl_pkg::job_t         dj_s   [DS];
	logic [FB:0]           drem_s [2][DS];
	logic [QW-1:0]         dq_s   [2][DS];
	logic [QW-1:0]         dnum_s [2][DS];
	logic                  dovf_s [2][DS];
	logic                  dzero_s[2][DS];

	// blend
	logic [QW-1:0]         wts [2];
	logic                  v_mx_s;
	qsl_pkg::job_t         j_mx_s;
	logic signed [PAW-1:0] pa_mx_s [4];
	logic signed [PBW-1:0] pb_mx_s [4];

	logic signed [ACW-1:0] acc [4];
	logic signed [CB+1:0]  absum [4];
	qsl_pkg::rs_t          slr [4];
	qsl_pkg::rs_t          avg [4];
	qsl_pkg::comp_t [3:0]  res_d;
	logic                  sat_d;

	qsl_pkg::comp_t [3:0]  res_q;
	qsl_pkg::path_t        path_q;
	logic                  sat_q;
	logic                  out_v_q;

	assign en        = !out_v_q || out_ready;
	assign pop_ready = en;

	for (genvar k = 0; k < STEPS; k++) begin : g_vec
		logic                 v_in;
		qsl_pkg::job_t        j_in;
		logic signed [VW-1:0] x_in, y_in, dx, dy;
		logic signed [ZW-1:0] z_in;

		if (k == 0) begin : g_head
			assign v_in = pop_valid;
			assign j_in = pop_job;
			assign x_in = VW'({pop_job.c, {SCALE{1'b0}}});
			assign y_in = VW'({pop_job.s, {SCALE{1'b0}}});
			assign z_in = '0;
		end else begin : g_body
			assign v_in = vv_s[k-1];
			assign j_in = vj_s[k-1];
			assign x_in = vx_s[k-1];
			assign y_in = vy_s[k-1];
			assign z_in = vz_s[k-1];
		end

		assign dx = y_in >>> k;
		assign dy = x_in >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[k] <= 1'b0;
			end else if (en) begin
				vv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vj_s[k] <= j_in;
				if (!y_in[VW-1]) begin
					vx_s[k] <= x_in + dx;
					vy_s[k] <= y_in - dy;
					vz_s[k] <= z_in + ZW'(qsl_pkg::atan_at(k));
				end else begin
					vx_s[k] <= x_in - dx;
					vy_s[k] <= y_in + dy;
					vz_s[k] <= z_in - ZW'(qsl_pkg::atan_at(k));
				end
			end
		end
	end

	// A negative angle is clamped to zero.
	assign hz = vz_s[STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_mul_s <= 1'b0;
			v_ang_s <= 1'b0;
		end else if (en) begin
			v_mul_s <= vv_s[STEPS-1];
			v_ang_s <= v_mul_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			j_mul_s  <= vj_s[STEPS-1];
			h_mul_s  <= hz[ZW-1] ? '0 : hz[HW-1:0];
			th_mul_s <= (FB + HW + 1)'(vj_s[STEPS-1].t) *
			            (FB + HW + 1)'(hz[ZW-1] ? '0 : hz[HW-1:0]);
			j_ang_s  <= j_mul_s;
			ang_s[0] <= h_mul_s - th_mul_s[FB+HW-1:FB];
			ang_s[1] <= th_mul_s[FB+HW-1:FB];
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_rot
		logic          v_in;
		qsl_pkg::job_t j_in;

		if (k == 0) begin : g_head
			assign v_in = v_ang_s;
			assign j_in = j_ang_s;
		end else begin : g_body
			assign v_in = rv_s[k-1];
			assign j_in = rj_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[k] <= 1'b0;
			end else if (en) begin
				rv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rj_s[k] <= j_in;
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic signed [VW-1:0] x_in, y_in, dx, dy;
			logic signed [ZW-1:0] z_in;

			if (k == 0) begin : g_head
				assign x_in = VW'(qsl_pkg::INV_GAIN);
				assign y_in = '0;
				assign z_in = ZW'(ang_s[l]);
			end else begin : g_body
				assign x_in = rx_s[l][k-1];
				assign y_in = ry_s[l][k-1];
				assign z_in = rz_s[l][k-1];
			end

			assign dx = y_in >>> k;
			assign dy = x_in >>> k;

			always_ff @(posedge clk) begin
				if (en) begin
					if (!z_in[ZW-1]) begin
						rx_s[l][k] <= x_in - dx;
						ry_s[l][k] <= y_in + dy;
						rz_s[l][k] <= z_in - ZW'(qsl_pkg::atan_at(k));
					end else begin
						rx_s[l][k] <= x_in + dx;
						ry_s[l][k] <= y_in - dy;
						rz_s[l][k] <= z_in + ZW'(qsl_pkg::atan_at(k));
					end
				end
			end
		end
	end

	// Weight = sine * 2^F / s, one quotient bit per stage. A quotient that
	// would need more than QW bits is flagged in the first stage and clamped.
	for (genvar k = 0; k < DS; k++) begin : g_div
		logic           v_in;
		qsl_pkg::job_t  j_in;

		if (k == 0) begin : g_head
			assign v_in = rv_s[STEPS-1];
			assign j_in = rj_s[STEPS-1];
		end else begin : g_body
			assign v_in = dv_s[k-1];
			assign j_in = dj_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en) begin
				dv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dj_s[k] <= j_in;
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [FB:0]    rem_in;
			logic [QW-1:0]  q_in, num_in;
			logic           ovf_in, zero_in;
			logic [FB+1:0]  rem2;
			logic [FB+1:0]  rdiff;
			logic           ge;

			if (k == 0) begin : g_head
				logic [NW-1:0] numer;
				assign numer   = {ry_s[l][STEPS-1][VW-2:0], {FB{1'b0}}};
				assign zero_in = ry_s[l][STEPS-1][VW-1];
				assign ovf_in  = numer[NW-1:QW] >= (NW - QW)'(rj_s[STEPS-1].s);
				assign rem_in  = numer[QW+FB:QW];
				assign num_in  = numer[QW-1:0];
				assign q_in    = '0;
			end else begin : g_body
				assign zero_in = dzero_s[l][k-1];
				assign ovf_in  = dovf_s[l][k-1];
				assign rem_in  = drem_s[l][k-1];
				assign num_in  = dnum_s[l][k-1];
				assign q_in    = dq_s[l][k-1];
			end

			assign rem2  = {rem_in, num_in[QW-1-k]};
			assign rdiff = rem2 - (FB + 2)'(j_in.s);
			assign ge    = rem2 >= (FB + 2)'(j_in.s);

			always_ff @(posedge clk) begin
				if (en) begin
					dzero_s[l][k] <= zero_in;
					dovf_s[l][k]  <= ovf_in;
					dnum_s[l][k]  <= num_in;
					dq_s[l][k]    <= {q_in[QW-2:0], ge};
					drem_s[l][k]  <= ge ? rdiff[FB:0] : rem2[FB:0];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (dzero_s[l][DS-1]) begin
				wts[l] = '0;
			end else if (dovf_s[l][DS-1] || (dq_s[l][DS-1] > W_ONE)) begin
				wts[l] = W_ONE;
			end else begin
				wts[l] = dq_s[l][DS-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_mx_s  <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_mx_s  <= dv_s[DS-1];
			out_v_q <= v_mx_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			j_mx_s <= dj_s[DS-1];
			for (int i = 0; i < 4; i++) begin
				pa_mx_s[i] <= $signed(dj_s[DS-1].a[i]) * $signed({1'b0, wts[0]});
				pb_mx_s[i] <= $signed(dj_s[DS-1].b[i]) * $signed({1'b0, wts[1]});
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			acc[i]   = ACW'(pa_mx_s[i]) + ACW'(pb_mx_s[i]) + ROUND;
			slr[i]   = acc[i][ACW-1:ANG];
			absum[i] = (CB + 2)'($signed(j_mx_s.a[i])) + (CB + 2)'($signed(j_mx_s.b[i]));
			avg[i]   = RSW'($signed(absum[i][CB+1:1]));
		end
		res_d = j_mx_s.a;
		sat_d = 1'b0;
		case (j_mx_s.path)
			qsl_pkg::PATH_FIRST: begin
				res_d = j_mx_s.a;
			end
			qsl_pkg::PATH_AVG: begin
				for (int i = 0; i < 4; i++) begin
					res_d[i] = qsl_pkg::sat_comp(avg[i]);
					sat_d    = sat_d | qsl_pkg::sat_hit(avg[i]);
				end
			end
			default: begin
				for (int i = 0; i < 4; i++) begin
					res_d[i] = qsl_pkg::sat_comp(slr[i]);
					sat_d    = sat_d | qsl_pkg::sat_hit(slr[i]);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q  <= res_d;
			sat_q  <= sat_d;
			path_q <= j_mx_s.path;
		end
	end

	assign out_valid = out_v_q;
	assign res       = res_q;
	assign path      = path_q;
	assign sat       = sat_q;

endmodule

`default_nettype wire

/* rtl/quaternion_slerp.sv */
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point spherical linear interpolation of two Q2.14 quaternions.
// ----------------------------------------------------------------------------
// The block accepts one quaternion pair per clock and delivers one result per
// clock while out_ready stays high. An item passes through the front (dot
// product, then one square-root bit per stage), the four-entry queue and the
// back, which holds the two 30-step CORDIC pipelines and the 31-step weight
// divider. The threshold register is at byte address 0 and should be written
// while no items are in flight.
`default_nettype none

module quaternion_slerp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] first_x,
	input  wire logic [15:0] first_y,
	input  wire logic [15:0] first_z,
	input  wire logic [15:0] first_w,
	input  wire logic [15:0] second_x,
	input  wire logic [15:0] second_y,
	input  wire logic [15:0] second_z,
	input  wire logic [15:0] second_w,
	input  wire logic [14:0] blend_fraction,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      out_x,
	output logic [15:0]      out_y,
	output logic [15:0]      out_z,
	output logic [15:0]      out_w,
	output logic [1:0]       path_taken,
	output logic             saturated
);

	localparam int FB = qsl_pkg::FB;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam qsl_pkg::frac_t THR_RESET = (FB + 1)'(16);

	qsl_pkg::frac_t        thr_q;
	qsl_pkg::comp_t [3:0]  a_in, b_in, res;
	logic                  f_valid, f_ready, b_valid, b_ready;
	qsl_pkg::job_t         f_job, b_job;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
			thr_q <= pwdata[FB:0];
		end
	end

	assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(thr_q) : '0;

	assign a_in = {first_w, first_z, first_y, first_x};
	assign b_in = {second_w, second_z, second_y, second_x};

	qsl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.a_in       (a_in),
		.b_in       (b_in),
		.t_in       (blend_fraction),
		.thr        (thr_q),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job)
	);

	qsl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_job    (b_job)
	);

	qsl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_job    (b_job),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res),
		.path       (path_taken),
		.sat        (saturated)
	);

	assign out_x = res[0];
	assign out_y = res[1];
	assign out_z = res[2];
	assign out_w = res[3];

endmodule

`default_nettype wire

/* tb/quaternion_slerp_checker.sv */
// ----------------------------------------------------------------------------
// quaternion_slerp_checker
// Watches the input and output channels of the slerp block, predicts every
// result from the accepted inputs and the threshold register, and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [15:0] first_x,
	input  wire logic [15:0] first_y,
	input  wire logic [15:0] first_z,
	input  wire logic [15:0] first_w,
	input  wire logic [15:0] second_x,
	input  wire logic [15:0] second_y,
	input  wire logic [15:0] second_z,
	input  wire logic [15:0] second_w,
	input  wire logic [14:0] blend_fraction,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [15:0] out_x,
	input  wire logic [15:0] out_y,
	input  wire logic [15:0] out_z,
	input  wire logic [15:0] out_w,
	input  wire logic [1:0]  path_taken,
	input  wire logic        saturated,
	output int               fail_count,
	output int               pending_count
);

	localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
	localparam longint Q1 = 64'sd1 << 14;

	typedef struct packed {
		logic [3:0][15:0]  q;
		qsl_pkg::path_t    path;
		logic              sat;
	} blend_t;

	blend_t slerp_queue[$];
	logic [14:0] threshold;

	function automatic longint fdiv(input longint v, input int sh);
		return v >>> sh;
	endfunction

	function automatic longint arc_tab(input int i);
		longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021686,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10) return tab[i];
		return 64'sd1 << (30 - i);
	endfunction

	function automatic longint half_angle(input longint x0, input longint y0);
		longint x, y, z, dx, dy;
		x = x0; y = y0; z = 0;
		for (int i = 0; i < 30; i++) begin
			dx = fdiv(y, i); dy = fdiv(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += arc_tab(i);
			end else begin
				x -= dx; y += dy; z -= arc_tab(i);
			end
		end
		return z;
	endfunction

	function automatic longint sine_q30(input longint z0);
		longint x, y, z, dx, dy;
		x = 652032874; y = 0; z = z0;
		for (int i = 0; i < 30; i++) begin
			dx = fdiv(y, i); dy = fdiv(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_tab(i);
			end else begin
				x += dx; y -= dy; z += arc_tab(i);
			end
		end
		return y;
	endfunction

	function automatic longint blend_weight(input longint sn, input longint s);
		longint w;
		w = (sn * Q1) / s;
		if (w < 0) w = 0;
		if (w > (64'sd1 << 30)) w = 64'sd1 << 30;
		return w;
	endfunction

	function automatic longint clamp_comp(input longint v, inout logic hit);
		if (v > 32767) begin
			hit = 1; return 32767;
		end
		if (v < -32768) begin
			hit = 1; return -32768;
		end
		return v;
	endfunction

	function automatic blend_t predict_slerp(input logic [3:0][15:0] qa,
			input logic [3:0][15:0] qb, input logic [14:0] frac, input logic [14:0] thr);
		blend_t res;
		longint a[4], b[4], r[4];
		longint dot, t, s, h, hb, ha, wa, wb;
		logic hit;
		hit = 0;
		dot = 0;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(qa[i]));
			b[i] = longint'($signed(qb[i]));
			dot += a[i] * b[i];
		end
		dot = fdiv(dot, 14);
		t = frac > Q1 ? Q1 : longint'(frac);
		if (dot < 0) begin
			for (int i = 0; i < 4; i++) b[i] = -b[i];
			dot = -dot;
		end
		if (dot >= Q1) begin
			res.path = qsl_pkg::PATH_FIRST;
			for (int i = 0; i < 4; i++) r[i] = a[i];
		end else begin
			// Bisection keeps the root search short.
			longint lo, hi, mid, rad;
			rad = Q1 * Q1 - dot * dot;
			lo = 0; hi = Q1;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				if (mid * mid <= rad) lo = mid; else hi = mid - 1;
			end
			s = lo;
			if (s < longint'(thr)) begin
				res.path = qsl_pkg::PATH_AVG;
				for (int i = 0; i < 4; i++) r[i] = clamp_comp(fdiv(a[i] + b[i], 1), hit);
			end else begin
				h = half_angle(dot <<< 16, s <<< 16);
				if (h < 0) h = 0;
				hb = fdiv(t * h, 14);
				ha = h - hb;
				wa = blend_weight(sine_q30(ha), s);
				wb = blend_weight(sine_q30(hb), s);
				res.path = qsl_pkg::PATH_SLERP;
				for (int i = 0; i < 4; i++)
					r[i] = clamp_comp(fdiv(a[i] * wa + b[i] * wb + (64'sd1 << 29), 30), hit);
			end
		end
		for (int i = 0; i < 4; i++) res.q[i] = r[i][15:0];
		res.sat = hit;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold <= 15'd16;
			fail_count <= 0;
			pending_count <= 0;
			slerp_queue.delete();
		end else begin
			blend_t want;
			if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD)
				threshold <= pwdata[14:0];
			if (in_valid && in_ready)
				slerp_queue.push_back(predict_slerp({first_w, first_z, first_y, first_x},
					{second_w, second_z, second_y, second_x}, blend_fraction, threshold));
			if (out_valid && out_ready) begin
				if (slerp_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer at %0t", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					want = slerp_queue.pop_front();
					if (want.q != {out_w, out_z, out_y, out_x} || want.path != path_taken
							|| want.sat != saturated) begin
						if (fail_count < 10)
							$display("result mismatch: expected x%0d y%0d z%0d w%0d",
								$signed(want.q[0]), $signed(want.q[1]), $signed(want.q[2]),
								$signed(want.q[3]), " path %0d sat %0d,", want.path,
								want.sat, " got x%0d y%0d z%0d w%0d",
								$signed(out_x), $signed(out_y), $signed(out_z),
								$signed(out_w), " path %0d sat %0d", path_taken, saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= slerp_queue.size();
		end
	end
endmodule

`default_nettype wire

/* tb/quaternion_slerp_test.sv */
// ----------------------------------------------------------------------------
// quaternion_slerp_test
// Drives quaternion pairs and threshold settings into the slerp block under
// varying flow control; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp_test;

	localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready, in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [15:0] first_x = 0, first_y = 0, first_z = 0, first_w = 0;
	logic [15:0] second_x = 0, second_y = 0, second_z = 0, second_w = 0;
	logic [14:0] blend_fraction = 0;
	logic [15:0] out_x, out_y, out_z, out_w;
	logic [1:0] path_taken;
	logic saturated;
	int fail_count, pending_count;
	int send_idle_pct = 0, stall_pct = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	quaternion_slerp uut (.*);
	quaternion_slerp_checker checker_i (.*);

	// Receiver stalls at random, changing on the falling edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic write_threshold(input logic [14:0] v);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= ADDR_THRESHOLD; pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Holds valid until the transfer; idles only between items.
	task automatic send_pair(input logic [3:0][15:0] qa, input logic [3:0][15:0] qb,
			input logic [14:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		{first_w, first_z, first_y, first_x} <= qa;
		{second_w, second_z, second_y, second_x} <= qb;
		blend_fraction <= t;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// A random near-unit quaternion, sometimes rough, sometimes close to a given one.
	function automatic logic [3:0][15:0] rand_quat(input logic [3:0][15:0] near);
		logic [3:0][15:0] q;
		int k, c[4];
		longint n2;
		k = $urandom_range(9);
		if (k == 0) begin
			for (int i = 0; i < 4; i++) q[i] = 16'($urandom);
			return q;
		end
		if (k <= 3) begin
			for (int i = 0; i < 4; i++)
				q[i] = near[i] + 16'($signed($urandom_range(2 ** $urandom_range(8))) -
					(2 ** $urandom_range(7)));
			return q;
		end
		n2 = 0;
		for (int i = 0; i < 4; i++) begin
			c[i] = int'($urandom_range(32767)) - 16384;
			n2 += longint'(c[i]) * c[i];
		end
		if (n2 == 0) n2 = 1;
		for (int i = 0; i < 4; i++)
			q[i] = 16'(longint'(c[i]) * 16384 / longint'($sqrt(real'(n2))));
		return q;
	endfunction

	logic [3:0][15:0] qa, qb;
	logic [14:0] thr_set[5] = '{15'd0, 15'd16384, 15'd16, 15'd2000, 15'd32767};

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (3) @(negedge clk);

		// Directed: identities, opposites, extremes, clamped fractions.
		send_pair({4{16'h4000}}, {4{16'h4000}}, 15'd8192);
		send_pair({16'h4000, 48'h0}, {16'h0, 16'h4000, 32'h0}, 15'd0);
		send_pair({16'h4000, 48'h0}, {16'h0, 16'h4000, 32'h0}, 15'd16384);
		send_pair({16'h4000, 48'h0}, {16'h0, 16'h4000, 32'h0}, 15'd32767);
		send_pair({16'h4000, 48'h0}, {16'hC000, 48'h0}, 15'd8192);
		send_pair({4{16'h7FFF}}, {4{16'h8000}}, 15'd4096);
		send_pair({4{16'h8000}}, {4{16'h8000}}, 15'd4096);
		send_pair({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF,
			16'h8000, 16'h7FFF}, 15'd16383);
		send_pair({16'h4000, 48'h0}, {16'h3FFF, 16'h0010, 32'h0}, 15'd8192);
		send_pair({16'h2D41, 16'h2D41, 32'h0}, {16'h2D41, 16'hD2BF, 32'h0}, 15'd1);
		send_pair({16'h0, 16'h0, 16'h4000, 16'h0}, {16'h0, 16'h0, 16'h0, 16'hC000}, 15'd16385);
		send_pair({64'h0}, {64'h0}, 15'd0);
		send_pair({16'h7FFF, 48'h0}, {16'h0, 16'h7FFF, 32'h0}, 15'd8192);
		send_pair({16'h8000, 48'h0}, {16'h0, 16'h8000, 32'h0}, 15'd8192);
		drain();

		qa = {16'h4000, 48'h0};
		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(thr_set[ph]);
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 51; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 51; end
				3: begin send_idle_pct = 16; stall_pct = 16; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			for (int n = 0; n < 310; n++) begin
				qa = rand_quat(qa);
				qb = rand_quat(qa);
				if ($urandom_range(3) == 0)
					for (int i = 0; i < 4; i++) qb[i] = -qb[i];
				send_pair(qa, qb, $urandom_range(7) == 0 ? 15'($urandom) :
					15'($urandom_range(16384)));
				// Hold off once, in the middle of the first phase, until the pipeline is empty.
				if (ph == 0 && n == 150) begin
					in_valid <= 0;
					while (pending_count != 0) @(negedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#30000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

`default_nettype wire
